FILE: rtl/core/sha_pkg.sv
package sha_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BLOCK_BYTES = 64;
	localparam logic [60:0] COUNT_MAX = {61{1'b1}};
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned LAST_ROUND = 63;
	localparam int unsigned LEN_SLOT = 56;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_LEN,
		ST_RUN,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
	} run_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} run_sts_t;

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

endpackage

FILE: rtl/core/sha_if.sv
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;
	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/core/sha_core.sv
module sha_core
	import sha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  run_ctl_t ctl,
	output run_sts_t sts,
	// block word write port from the loader
	input  logic       blk_we,
	input  logic [3:0] blk_waddr,
	input  word_t      blk_wdata,
	input  logic       hash_rst,
	input  logic [2:0] hash_raddr,
	output word_t      hash_rdata
);

	// 16-entry schedule ring: rounds 16..63 overwrite slot t%16
	word_t sched_mem [16];
	word_t hash_mem [8];
	word_t va_q, vb_q, vc_q, vd_q, ve_q, vf_q, vg_q, vh_q;
	logic [6:0] cnt_q;
	logic run_q, sum_q, done_q;
	logic [2:0] sum_idx_q;
	word_t w_t, w15, w2, w16, w7, s0, s1, w_new, t1, t2;
	logic [5:0] rnd;
	logic [3:0] ri;

	assign rnd = cnt_q[5:0];
	assign ri = rnd[3:0];
	assign w16 = sched_mem[ri];
	assign w15 = sched_mem[ri + 4'd1];
	assign w7 = sched_mem[ri + 4'd9];
	assign w2 = sched_mem[ri + 4'd14];
	assign s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
	assign s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
	assign w_new = w16 + s0 + w7 + s1;
	assign w_t = (rnd < 6'd16) ? w16 : w_new;
	assign t1 = vh_q + (rotr(ve_q, 6) ^ rotr(ve_q, 11) ^ rotr(ve_q, 25))
		+ ((ve_q & vf_q) ^ (~ve_q & vg_q)) + ROUND_K[rnd] + w_t;
	assign t2 = (rotr(va_q, 2) ^ rotr(va_q, 13) ^ rotr(va_q, 22))
		+ ((va_q & vb_q) ^ (va_q & vc_q) ^ (vb_q & vc_q));

	always_ff @(posedge clk) begin
		if (blk_we) begin
			sched_mem[blk_waddr] <= blk_wdata;
		end else if (run_q) begin
			sched_mem[ri] <= w_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			sum_q <= 1'b0;
			cnt_q <= '0;
			sum_idx_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (rnd == 6'(LAST_ROUND)) begin
					run_q <= 1'b0;
					sum_q <= 1'b1;
					sum_idx_q <= '0;
				end
			end else if (sum_q) begin
				sum_idx_q <= sum_idx_q + 3'd1;
				if (sum_idx_q == 3'd7) begin
					sum_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hash chaining value, one word added back per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_mem[i] <= INIT_H[i];
		end else if (hash_rst) begin
			for (int i = 0; i < 8; i++) hash_mem[i] <= INIT_H[i];
		end else if (sum_q) begin
			unique case (sum_idx_q)
				3'd0: hash_mem[0] <= hash_mem[0] + va_q;
				3'd1: hash_mem[1] <= hash_mem[1] + vb_q;
				3'd2: hash_mem[2] <= hash_mem[2] + vc_q;
				3'd3: hash_mem[3] <= hash_mem[3] + vd_q;
				3'd4: hash_mem[4] <= hash_mem[4] + ve_q;
				3'd5: hash_mem[5] <= hash_mem[5] + vf_q;
				3'd6: hash_mem[6] <= hash_mem[6] + vg_q;
				3'd7: hash_mem[7] <= hash_mem[7] + vh_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			va_q <= hash_mem[0]; vb_q <= hash_mem[1];
			vc_q <= hash_mem[2]; vd_q <= hash_mem[3];
			ve_q <= hash_mem[4]; vf_q <= hash_mem[5];
			vg_q <= hash_mem[6]; vh_q <= hash_mem[7];
		end else if (run_q) begin
			vh_q <= vg_q; vg_q <= vf_q; vf_q <= ve_q;
			ve_q <= vd_q + t1;
			vd_q <= vc_q; vc_q <= vb_q; vb_q <= va_q;
			va_q <= t1 + t2;
		end
	end

	assign sts.done = done_q;
	assign sts.busy = run_q | sum_q | ctl.start;
	assign hash_rdata = hash_mem[hash_raddr];

endmodule

FILE: rtl/core/sha256_stream_hash.sv
// channel  | dir | payload
// in_ch    | in  | data_byte[7:0], has_byte, end_of_message
// out_ch   | out | digest_word[31:0], word_index[2:0], last_word
// every 64th byte stalls in_ch while the core starts, runs its rounds,
// adds the eight hash words back and signals done
// an end transfer pads the block one byte slot at a time, runs one or two blocks,
// then presents eight digest words, one per accepted output transfer
// arst_n clears control; hash words return to the initial values
// out_ch stalls hold the digest sequence; in_ch is not ready until it ends
module sha256_stream_hash
	import sha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sha_in_if.sink in_ch,
	sha_out_if.source out_ch
);

	localparam int unsigned PW = $clog2(BLOCK_BYTES);

	state_t st_q, st_d;
	logic [PW-1:0] fill_q;
	logic [60:0] count_q;
	word_t word_q;
	logic [2:0] oidx_q;
	logic fin_q;
	logic [1:0] len_q;
	run_ctl_t ctl;
	run_sts_t sts;
	logic blk_we, hash_rst, put, acc;
	logic [3:0] blk_waddr;
	word_t blk_wdata, hash_rdata, packed_w;
	logic [7:0] put_byte;
	logic [63:0] bits;
	// pad state: first slot gets 0x80 through pad_first
	logic pad_first_q;

	assign acc = in_ch.valid & in_ch.ready;
	assign bits = {count_q, 3'b000};

	sha_core u_core (
		.clk, .arst_n, .ctl, .sts,
		.blk_we, .blk_waddr, .blk_wdata, .hash_rst,
		.hash_raddr(oidx_q), .hash_rdata
	);

	always_comb begin
		put = 1'b0;
		put_byte = PAD_BYTE;
		if (st_q == ST_LOAD && acc && in_ch.has_byte) begin
			put = 1'b1;
			put_byte = in_ch.data_byte;
		end else if (st_q == ST_PAD) begin
			put = 1'b1;
			put_byte = pad_first_q ? PAD_BYTE : 8'h00;
		end
	end

	// byte shifts into the word register; word written when its last byte lands
	assign packed_w = (fill_q[1:0] == 2'd0) ? {put_byte, 24'h0} :
		(word_q | (word_t'(put_byte) << ((3 - fill_q[1:0]) * 8)));

	always_comb begin
		blk_we = 1'b0;
		blk_waddr = fill_q[PW-1:2];
		blk_wdata = packed_w;
		if (st_q == ST_LEN) begin
			blk_we = 1'b1;
			blk_waddr = len_q[0] ? 4'd15 : 4'd14;
			blk_wdata = len_q[0] ? bits[31:0] : bits[63:32];
		end else if (put && fill_q[1:0] == 2'd3) begin
			blk_we = 1'b1;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_LOAD: if (acc) begin
				if (in_ch.has_byte && fill_q == PW'(BLOCK_BYTES - 1)) st_d = ST_RUN;
				else if (in_ch.end_of_message) st_d = ST_PAD;
			end
			ST_PAD: if (fill_q == PW'(LEN_SLOT - 1)) st_d = ST_LEN;
				else if (fill_q == PW'(BLOCK_BYTES - 1)) st_d = ST_RUN;
			ST_LEN: if (len_q[0]) st_d = ST_RUN;
			ST_RUN: st_d = ST_SUM;
			ST_SUM: if (sts.done) begin
				if (fin_q && len_q[1]) st_d = ST_OUT;
				else if (fin_q) st_d = ST_PAD;
				else st_d = ST_LOAD;
			end
			ST_OUT: if (out_ch.ready && oidx_q == 3'd7) st_d = ST_LOAD;
			default: st_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ch.ready = (st_q == ST_LOAD);
		out_ch.valid = (st_q == ST_OUT);
		out_ch.digest_word = hash_rdata;
		out_ch.word_index = oidx_q;
		out_ch.last_word = (oidx_q == 3'd7);
		ctl.start = (st_q == ST_RUN);
		hash_rst = (st_q == ST_OUT) && out_ch.ready && oidx_q == 3'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			fill_q <= '0;
			count_q <= '0;
			oidx_q <= '0;
			fin_q <= 1'b0;
			len_q <= '0;
			pad_first_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (put || (st_q == ST_PAD)) begin
				fill_q <= fill_q + PW'(1);
			end
			if (st_q == ST_LOAD && acc) begin
				if (in_ch.has_byte && count_q != COUNT_MAX) count_q <= count_q + 61'd1;
				if (in_ch.end_of_message) begin
					fin_q <= 1'b1;
					pad_first_q <= 1'b1;
				end
			end
			if (st_q == ST_PAD) pad_first_q <= 1'b0;
			if (st_q == ST_LEN) begin
				len_q <= {len_q[0], ~len_q[0]};
				if (len_q[0]) fill_q <= '0;
			end
			if (st_q == ST_OUT && out_ch.ready) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					fin_q <= 1'b0;
					len_q <= '0;
					count_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (put) word_q <= packed_w;
	end

endmodule

FILE: rtl/core/sha_checker.sv
module sha_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] word_index,
	input logic last_word
);

	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input ready during digest output");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last word flag mismatch");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> (out_valid && word_index == $past(word_index) + 3'd1))
		else $error("digest word order broken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(word_index))
		else $error("index moved under stall");

endmodule

bind sha256_stream_hash sha_checker u_chk (
	.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.word_index(out_ch.word_index), .last_word(out_ch.last_word)
);

FILE: bench/sha256_stream_hash_checker.sv
module sha256_stream_hash_checker
	import sha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sha_in_if.sink in_mon,
	sha_out_if.sink out_mon,
	output int fail_count,
	output int pending_words,
	output int digests_seen,
	output int bytes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} digest_rec_t;

	word_t       chain_h [8];
	word_t       msg_block [16];
	logic [60:0] msg_len;
	int          slot;
	digest_rec_t digest_q [$];

	function automatic word_t ror(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		word_t w [64];
		word_t v [8];
		word_t t1, t2;
		for (int i = 0; i < 16; i++) w[i] = msg_block[i];
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++) v[i] = chain_h[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain_h[i] += v[i];
	endtask

	task automatic pack_byte(logic [7:0] b);
		int wi;
		int sh;
		wi = slot >> 2;
		sh = (3 - (slot & 3)) * 8;
		if ((slot & 3) == 0)
			msg_block[wi] = word_t'(b) << sh;
		else
			msg_block[wi] |= word_t'(b) << sh;
		slot++;
		if (slot == 64) begin
			compress();
			slot = 0;
		end
	endtask

	task automatic take_item(logic [7:0] b, logic has, logic fin);
		logic [63:0] bits;
		digest_rec_t rec;
		if (has) begin
			pack_byte(b);
			if (msg_len != COUNT_MAX) msg_len++;
		end
		if (fin) begin
			bits = {msg_len, 3'b000};
			pack_byte(PAD_BYTE);
			while (slot != LEN_SLOT) pack_byte(8'h00);
			msg_block[14] = bits[63:32];
			msg_block[15] = bits[31:0];
			compress();
			slot = 0;
			for (int i = 0; i < 8; i++) begin
				rec.digest_word = chain_h[i];
				rec.word_index = 3'(i);
				rec.last_word = (i == 7);
				digest_q.push_back(rec);
			end
			chain_h = INIT_H;
			msg_len = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_rec_t exp_rec;
		int errs;
		if (!arst_n) begin
			chain_h = INIT_H;
			msg_len = '0;
			slot = 0;
			digest_q.delete();
			fail_count <= 0;
			digests_seen <= 0;
			bytes_seen <= 0;
		end else begin
			errs = 0;
			if (in_mon.valid && in_mon.ready) begin
				take_item(in_mon.data_byte, in_mon.has_byte, in_mon.end_of_message);
				if (in_mon.has_byte) bytes_seen <= bytes_seen + 1;
			end
			if (out_mon.valid && out_mon.ready) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest word %h", out_mon.digest_word);
					errs++;
				end else begin
					exp_rec = digest_q.pop_front();
					if (out_mon.digest_word !== exp_rec.digest_word) begin
						$error("digest_word expected %h actual %h",
							exp_rec.digest_word, out_mon.digest_word);
						errs++;
					end
					if (out_mon.word_index !== exp_rec.word_index) begin
						$error("word_index expected %0d actual %0d",
							exp_rec.word_index, out_mon.word_index);
						errs++;
					end
					if (out_mon.last_word !== exp_rec.last_word) begin
						$error("last_word expected %0b actual %0b",
							exp_rec.last_word, out_mon.last_word);
						errs++;
					end
					if (exp_rec.last_word) digests_seen <= digests_seen + 1;
				end
			end
			if (errs != 0) fail_count <= fail_count + errs;
		end
		pending_words = digest_q.size();
	end
endmodule

FILE: bench/sha256_stream_hash_test.sv
module sha256_stream_hash_test;
	import sha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   src_idle_pct = 0;
	int   snk_stall_pct = 0;
	bit   hold_off = 1'b0;
	int   cycles = 0;
	int   fail_count, pending_words, digests_seen, bytes_seen;

	sha_in_if  in_ch ();
	sha_out_if out_ch ();

	sha256_stream_hash u_top (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	sha256_stream_hash_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch), .out_mon(out_ch),
		.fail_count(fail_count), .pending_words(pending_words),
		.digests_seen(digests_seen), .bytes_seen(bytes_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// output side stalls at random unless held off
	always @(posedge clk) begin
		if (!arst_n || hold_off)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// one transfer, with random idle cycles ahead of it
	task automatic send_item(logic [7:0] b, logic has, logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.has_byte <= has;
		in_ch.end_of_message <= fin;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic send_message(int len, bit zero_content);
		for (int i = 0; i < len; i++)
			send_item(zero_content ? 8'h00 : 8'($urandom), 1'b1, 1'b0);
		send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_phase(int idle, int stall, int count);
		int len;
		src_idle_pct = idle;
		snk_stall_pct = stall;
		while (count > 0) begin
			case ($urandom_range(9))
				0: begin
					send_item(8'($urandom), 1'($urandom), 1'($urandom));
					count--;
				end
				1: begin
					send_item(8'($urandom), 1'b0, 1'b0);
				end
				default: begin
					len = $urandom_range(4) == 0 ? $urandom_range(50, 130) : $urandom_range(0, 20);
					if (len > count) len = count;
					for (int i = 0; i < len; i++)
						send_item(8'($urandom), 1'b1, 1'b0);
					send_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
					count -= len + 1;
				end
			endcase
		end
	endtask

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.data_byte <= '0;
		in_ch.has_byte <= 1'b0;
		in_ch.end_of_message <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h55, 1'b0, 1'b1);
		send_item(8'haa, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b1);
		wait_drained();

		// padding boundaries: 55, 56 and 64 bytes
		send_message(55, 1'b0);
		send_message(56, 1'b1);
		send_message(64, 1'b0);
		wait_drained();

		random_phase(0, 0, 10);
		random_phase(62, 0, 8);
		random_phase(0, 62, 8);
		random_phase(25, 25, 6);

		// long output hold-off while input keeps offering
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_off = 1'b1;
		fork
			begin
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_message(3, 1'b0);
				send_message(5, 1'b0);
				send_message(2, 1'b0);
			end
		join
		wait_drained();

		$display("covered %0d bytes and %0d digests, with idle and stall mixes",
			bytes_seen, digests_seen);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
